// ===== src/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types, codes and helper functions of the scripted envelope generator.
// ----------------------------------------------------------------------------
package sae_pkg;

    localparam int ENV_DEPTH_DEF    = 16;
    localparam int SUSTAIN_HOLD_DEF = 128;

    localparam int ENTRY_W = 31;
    localparam int DVD_W   = 28;
    localparam int DVS_W   = 16;

    localparam logic signed [15:0] DLY_DISABLE = 16'sd0;
    localparam logic signed [15:0] DLY_HANG    = -16'sd1;
    localparam logic signed [15:0] DLY_GOTO    = -16'sd2;
    localparam logic signed [15:0] DLY_RESTART = -16'sd3;
    localparam logic signed [15:0] DLY_SCALE   = 16'sd4;

    localparam logic signed [26:0] LVL_MAX     = 27'sh3FFFFFF;
    localparam logic signed [26:0] LVL_MIN     = -27'sh4000000;
    localparam logic signed [26:0] SILENCE_Q24 = 27'sd168;

    localparam int ACT_HANG    = 0;
    localparam int ACT_DECAY   = 1;
    localparam int ACT_RELEASE = 2;

    localparam logic [1:0] REG_UPF = 2'd0;
    localparam logic [1:0] REG_DIV = 2'd1;
    localparam logic [1:0] REG_SUS = 2'd2;
    localparam logic [1:0] REG_FOS = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_WRITE = 3'd1,
        OP_INIT  = 3'd2,
        OP_START = 3'd3,
        OP_POST  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_OFF       = 4'd0,
        ST_INITIAL   = 4'd1,
        ST_STARTLOOP = 4'd2,
        ST_LOOP      = 4'd3,
        ST_FADE      = 4'd4,
        ST_HANG      = 4'd5,
        ST_DECAY     = 4'd6,
        ST_RELEASE   = 4'd7,
        ST_SUSTAIN   = 4'd8
    } t_stage;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_STEP,
        SQ_READ,
        SQ_EVAL,
        SQ_MUL,
        SQ_SCALE,
        SQ_SCALE_WAIT,
        SQ_DIFF,
        SQ_QDIV,
        SQ_QWAIT,
        SQ_FADE,
        SQ_FINISH
    } t_seq;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         entry_index;
        logic signed [15:0] entry_delay;
        logic [14:0]        entry_arg;
        logic               hang_request;
        logic               decay_request;
        logic               release_request;
    } t_in_word;

    typedef struct packed {
        logic [15:0] level;
        logic [3:0]  stage;
    } t_out_word;

    typedef struct packed {
        logic               en;
        logic [3:0]         addr;
        logic [ENTRY_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic signed [26:0] sat27(input logic signed [28:0] v);
        logic signed [26:0] r;
        if (v > 29'(LVL_MAX)) begin
            r = LVL_MAX;
        end else if (v < 29'(LVL_MIN)) begin
            r = LVL_MIN;
        end else begin
            r = v[26:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] level_out(input logic signed [26:0] l);
        logic [15:0] r;
        if (l[26]) begin
            r = 16'd0;
        end else if (l[25:24] != 2'b00) begin
            r = 16'hFFFF;
        end else begin
            r = l[23:8];
        end
        return r;
    endfunction

endpackage

// ===== src/sae_script_mem.sv =====
// ----------------------------------------------------------------------------
// sae_script_mem
// Sixteen-entry script memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sae_script_mem (
    input  logic                         i_clk,
    input  sae_pkg::t_mem_wr             i_wr,
    input  logic [3:0]                   i_raddr,
    output logic [sae_pkg::ENTRY_W-1:0]  o_rdata
);

    logic [sae_pkg::ENTRY_W-1:0] r_mem [16];
    logic [sae_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sae_div.sv =====
// ----------------------------------------------------------------------------
// sae_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sae_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sae_pkg::t_div_req i_req,
    output sae_pkg::t_div_rsp o_rsp
);

    localparam int DVD_W = sae_pkg::DVD_W;
    localparam int DVS_W = sae_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_sh;
    logic             w_ge;
    logic [DVS_W:0]   w_sub;

    assign w_sh  = {r_rem, r_quo[DVD_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== src/sae_ctrl.sv =====
// ----------------------------------------------------------------------------
// sae_ctrl
// Envelope state and the sequencer that steps the stages and walks the script.
// ----------------------------------------------------------------------------
module sae_ctrl #(
    parameter int ENV_DEPTH    = sae_pkg::ENV_DEPTH_DEF,
    parameter int SUSTAIN_HOLD = sae_pkg::SUSTAIN_HOLD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  sae_pkg::t_in_word            i_word,
    output logic                         o_busy,
    output logic                         o_valid,
    output sae_pkg::t_out_word           o_word,
    input  logic [7:0]                   i_upf,
    input  logic [7:0]                   i_dvr,
    input  logic [23:0]                  i_sus,
    input  logic [23:0]                  i_fos,
    output sae_pkg::t_mem_wr             o_mem_wr,
    output logic [3:0]                   o_mem_raddr,
    input  logic [sae_pkg::ENTRY_W-1:0]  i_mem_rdata,
    output sae_pkg::t_div_req            o_div_req,
    input  sae_pkg::t_div_rsp            i_div_rsp
);

    localparam int HOP_W = $clog2(ENV_DEPTH + 1);

    sae_pkg::t_seq      r_seq, n_seq;
    sae_pkg::t_stage    r_stage, n_stage;
    logic [2:0]         r_flags, n_flags;
    logic [3:0]         r_ptr, n_ptr;
    logic [15:0]        r_tc, n_tc;
    logic signed [26:0] r_level, n_level;
    logic signed [26:0] r_fstep, n_fstep;
    logic [HOP_W-1:0]   r_hops, n_hops;
    logic signed [15:0] r_d, n_d;
    logic [14:0]        r_arg, n_arg;
    logic [23:0]        r_target, n_target;
    logic [22:0]        r_prod, n_prod;
    logic signed [16:0] r_dd, n_dd;
    logic signed [27:0] r_diff, n_diff;
    logic               r_valid, n_valid;
    sae_pkg::t_out_word r_out, n_out;

    logic               w_accept;
    logic signed [15:0] w_e_dly;
    logic [14:0]        w_e_arg;
    logic               w_goto_cut;
    logic [29:0]        w_sq;
    logic [22:0]        w_prod;
    logic [25:0]        w_sc_q;
    logic [15:0]        w_sc;
    logic signed [16:0] w_dd_neg;
    logic signed [27:0] w_diff_neg;
    logic signed [28:0] w_qs;
    logic signed [28:0] w_fsum;
    logic signed [28:0] w_dsub;
    logic signed [26:0] w_cur;
    logic [15:0]        w_tc_dec;

    assign w_accept   = i_start && (r_seq == sae_pkg::SQ_IDLE);
    assign w_e_dly    = signed'(i_mem_rdata[30:15]);
    assign w_e_arg    = i_mem_rdata[14:0];
    assign w_goto_cut = (r_hops >= HOP_W'(ENV_DEPTH));
    assign w_sq       = r_arg * r_arg;
    assign w_prod     = r_d[14:0] * i_upf;
    assign w_sc_q     = i_div_rsp.quotient[27:2];
    assign w_dd_neg   = -r_dd;
    assign w_diff_neg = -r_diff;
    assign w_fsum     = 29'(r_level) + 29'(r_fstep);
    assign w_dsub     = 29'(r_level) - signed'({5'd0, i_fos});
    assign w_cur      = sae_pkg::sat27(w_dsub);
    assign w_tc_dec   = r_tc - 16'd1;

    always_comb begin
        if (w_sc_q[25:16] != '0) begin
            w_sc = 16'hFFFF;
        end else if (w_sc_q[15:0] == 16'd0) begin
            w_sc = 16'd1;
        end else begin
            w_sc = w_sc_q[15:0];
        end
    end

    always_comb begin
        if (r_diff[27] ^ r_dd[16]) begin
            w_qs = -signed'({1'b0, i_div_rsp.quotient});
        end else begin
            w_qs = signed'({1'b0, i_div_rsp.quotient});
        end
    end

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            sae_pkg::SQ_IDLE: begin
                if (w_accept && i_word.operation == sae_pkg::OP_TICK &&
                    r_stage != sae_pkg::ST_OFF) begin
                    n_seq = sae_pkg::SQ_STEP;
                end
            end
            sae_pkg::SQ_STEP: begin
                case (r_stage)
                    sae_pkg::ST_INITIAL: begin
                        n_seq = r_flags[sae_pkg::ACT_HANG] ? sae_pkg::SQ_FINISH
                                                           : sae_pkg::SQ_READ;
                    end
                    sae_pkg::ST_STARTLOOP, sae_pkg::ST_LOOP: begin
                        n_seq = sae_pkg::SQ_READ;
                    end
                    sae_pkg::ST_FADE: begin
                        n_seq = sae_pkg::SQ_FADE;
                    end
                    default: begin
                        n_seq = sae_pkg::SQ_FINISH;
                    end
                endcase
            end
            sae_pkg::SQ_READ: begin
                n_seq = sae_pkg::SQ_EVAL;
            end
            sae_pkg::SQ_EVAL: begin
                if (w_e_dly == sae_pkg::DLY_DISABLE || w_e_dly == sae_pkg::DLY_HANG ||
                    w_e_dly == sae_pkg::DLY_RESTART) begin
                    n_seq = sae_pkg::SQ_FINISH;
                end else if (w_e_dly == sae_pkg::DLY_GOTO) begin
                    n_seq = w_goto_cut ? sae_pkg::SQ_FINISH : sae_pkg::SQ_READ;
                end else begin
                    n_seq = sae_pkg::SQ_MUL;
                end
            end
            sae_pkg::SQ_MUL: begin
                n_seq = (r_d >= sae_pkg::DLY_SCALE) ? sae_pkg::SQ_SCALE : sae_pkg::SQ_DIFF;
            end
            sae_pkg::SQ_SCALE: begin
                n_seq = sae_pkg::SQ_SCALE_WAIT;
            end
            sae_pkg::SQ_SCALE_WAIT: begin
                if (i_div_rsp.done) begin
                    n_seq = sae_pkg::SQ_DIFF;
                end
            end
            sae_pkg::SQ_DIFF: begin
                n_seq = sae_pkg::SQ_QDIV;
            end
            sae_pkg::SQ_QDIV: begin
                n_seq = sae_pkg::SQ_QWAIT;
            end
            sae_pkg::SQ_QWAIT: begin
                if (i_div_rsp.done) begin
                    n_seq = sae_pkg::SQ_FADE;
                end
            end
            sae_pkg::SQ_FADE: begin
                n_seq = sae_pkg::SQ_FINISH;
            end
            sae_pkg::SQ_FINISH: begin
                n_seq = sae_pkg::SQ_IDLE;
            end
            default: begin
                n_seq = sae_pkg::SQ_IDLE;
            end
        endcase
    end

    always_comb begin
        n_stage  = r_stage;
        n_flags  = r_flags;
        n_ptr    = r_ptr;
        n_tc     = r_tc;
        n_level  = r_level;
        n_fstep  = r_fstep;
        n_hops   = r_hops;
        n_d      = r_d;
        n_arg    = r_arg;
        n_target = r_target;
        n_prod   = r_prod;
        n_dd     = r_dd;
        n_diff   = r_diff;
        n_valid  = 1'b0;
        n_out    = r_out;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = i_word.entry_index;
        o_mem_wr.data = {i_word.entry_delay, i_word.entry_arg};
        o_div_req.start    = 1'b0;
        o_div_req.dividend = 28'(r_prod);
        o_div_req.divisor  = (i_dvr == 8'd0) ? 16'd1 : {8'd0, i_dvr};

        case (r_seq)
            sae_pkg::SQ_IDLE: begin
                if (w_accept) begin
                    n_hops = '0;
                    case (i_word.operation)
                        sae_pkg::OP_TICK: begin
                        end
                        sae_pkg::OP_WRITE: begin
                            o_mem_wr.en = 1'b1;
                        end
                        sae_pkg::OP_INIT: begin
                            n_flags = '0;
                            n_stage = sae_pkg::ST_OFF;
                            n_tc    = '0;
                            n_level = '0;
                        end
                        sae_pkg::OP_START: begin
                            n_stage = sae_pkg::ST_INITIAL;
                        end
                        sae_pkg::OP_POST: begin
                            n_flags = r_flags | {i_word.release_request,
                                                 i_word.decay_request,
                                                 i_word.hang_request};
                        end
                        default: begin
                        end
                    endcase
                    if (i_word.operation != sae_pkg::OP_TICK ||
                        r_stage == sae_pkg::ST_OFF) begin
                        n_valid     = 1'b1;
                        n_out.stage = n_stage;
                        n_out.level = (n_stage == sae_pkg::ST_OFF) ? 16'd0
                                                                   : sae_pkg::level_out(n_level);
                    end
                end
            end
            sae_pkg::SQ_STEP: begin
                case (r_stage)
                    sae_pkg::ST_INITIAL: begin
                        if (r_flags[sae_pkg::ACT_HANG]) begin
                            n_stage = sae_pkg::ST_HANG;
                        end else begin
                            n_ptr   = '0;
                            n_stage = sae_pkg::ST_LOOP;
                        end
                    end
                    sae_pkg::ST_STARTLOOP: begin
                        n_ptr   = '0;
                        n_stage = sae_pkg::ST_LOOP;
                    end
                    sae_pkg::ST_DECAY, sae_pkg::ST_RELEASE: begin
                        n_level = w_cur;
                        if (i_sus != 24'd0 && r_stage == sae_pkg::ST_DECAY) begin
                            if (w_cur < signed'({3'd0, i_sus})) begin
                                n_level = signed'({3'd0, i_sus});
                                n_tc    = 16'(SUSTAIN_HOLD);
                                n_stage = sae_pkg::ST_SUSTAIN;
                            end
                        end else if (w_cur < sae_pkg::SILENCE_Q24) begin
                            n_level = '0;
                            n_stage = sae_pkg::ST_OFF;
                        end
                    end
                    sae_pkg::ST_SUSTAIN: begin
                        n_tc = w_tc_dec;
                        if (w_tc_dec == 16'd0) begin
                            n_stage = sae_pkg::ST_RELEASE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sae_pkg::SQ_EVAL: begin
                if (w_e_dly == sae_pkg::DLY_DISABLE) begin
                    n_stage = sae_pkg::ST_OFF;
                end else if (w_e_dly == sae_pkg::DLY_HANG) begin
                    n_stage = sae_pkg::ST_HANG;
                end else if (w_e_dly == sae_pkg::DLY_RESTART) begin
                    n_stage = sae_pkg::ST_INITIAL;
                end else if (w_e_dly == sae_pkg::DLY_GOTO) begin
                    if (w_goto_cut) begin
                        n_stage = sae_pkg::ST_OFF;
                    end else begin
                        n_ptr  = w_e_arg[3:0];
                        n_hops = r_hops + HOP_W'(1);
                    end
                end else begin
                    n_d   = w_e_dly;
                    n_arg = w_e_arg;
                end
            end
            sae_pkg::SQ_MUL: begin
                n_target = w_sq[29:6];
                n_prod   = w_prod;
                if (r_d < sae_pkg::DLY_SCALE) begin
                    n_dd = 17'(r_d);
                    n_tc = r_d[15] ? 16'd0 : r_d;
                end
            end
            sae_pkg::SQ_SCALE: begin
                o_div_req.start = 1'b1;
            end
            sae_pkg::SQ_SCALE_WAIT: begin
                if (i_div_rsp.done) begin
                    n_dd = signed'({1'b0, w_sc});
                    n_tc = w_sc;
                end
            end
            sae_pkg::SQ_DIFF: begin
                n_diff = signed'({4'd0, r_target}) - 28'(r_level);
            end
            sae_pkg::SQ_QDIV: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_diff[27] ? w_diff_neg : r_diff;
                o_div_req.divisor  = r_dd[16] ? w_dd_neg[15:0] : r_dd[15:0];
            end
            sae_pkg::SQ_QWAIT: begin
                if (i_div_rsp.done) begin
                    n_fstep = sae_pkg::sat27(w_qs);
                    n_stage = sae_pkg::ST_FADE;
                    n_ptr   = r_ptr + 4'd1;
                end
            end
            sae_pkg::SQ_FADE: begin
                n_level = sae_pkg::sat27(w_fsum);
                if (r_tc <= 16'd1) begin
                    n_tc    = '0;
                    n_stage = sae_pkg::ST_LOOP;
                end else begin
                    n_tc = w_tc_dec;
                end
            end
            sae_pkg::SQ_FINISH: begin
                if (r_flags[sae_pkg::ACT_DECAY]) begin
                    n_stage = sae_pkg::ST_DECAY;
                    n_flags[sae_pkg::ACT_DECAY] = 1'b0;
                end
                if (r_flags[sae_pkg::ACT_RELEASE]) begin
                    n_stage = sae_pkg::ST_RELEASE;
                    n_flags[sae_pkg::ACT_RELEASE] = 1'b0;
                end
                n_valid     = 1'b1;
                n_out.stage = n_stage;
                n_out.level = sae_pkg::level_out(r_level);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= sae_pkg::SQ_IDLE;
            r_stage <= sae_pkg::ST_OFF;
            r_flags <= '0;
            r_ptr   <= '0;
            r_tc    <= '0;
            r_level <= '0;
            r_fstep <= '0;
            r_hops  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_seq   <= n_seq;
            r_stage <= n_stage;
            r_flags <= n_flags;
            r_ptr   <= n_ptr;
            r_tc    <= n_tc;
            r_level <= n_level;
            r_fstep <= n_fstep;
            r_hops  <= n_hops;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_arg    <= n_arg;
        r_target <= n_target;
        r_prod   <= n_prod;
        r_dd     <= n_dd;
        r_diff   <= n_diff;
        r_out    <= n_out;
    end

    assign o_busy      = (r_seq != sae_pkg::SQ_IDLE);
    assign o_valid     = r_valid;
    assign o_word      = r_out;
    assign o_mem_raddr = r_ptr;

endmodule

// ===== src/scripted_adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// scripted_adsr_envelope_generator
// Script-driven envelope generator with an APB register port.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every word
// gives exactly one result word on o_word, shown for one cycle with o_valid.
// Script writes, init, start and flag posts skip the sequencer: the result
// appears in the cycle after the word is taken and busy never rises.
// A tick while the envelope is off also skips it. Other ticks run through
// the sequencer: a step state, a read and an evaluate state for every script
// entry read from the script memory (gotos included, up to ENV_DEPTH of
// them), and for a new fade entry a multiply state, a serial divider pass
// to scale delays of DLY_SCALE or more, a difference state, a second pass
// for the fade step, then fade and finish. busy is high for the whole tick.
// Reset clears the envelope state to off and loads the register defaults;
// the script memory holds whatever was last written. The receiver cannot
// stall: each result word must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module scripted_adsr_envelope_generator #(
    parameter int ENV_DEPTH    = sae_pkg::ENV_DEPTH_DEF,
    parameter int SUSTAIN_HOLD = sae_pkg::SUSTAIN_HOLD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sae_pkg::t_in_word  i_word,
    output logic               o_valid,
    output sae_pkg::t_out_word o_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]  r_upf;
    logic [7:0]  r_dvr;
    logic [23:0] r_sus;
    logic [23:0] r_fos;

    logic                        w_wr;
    sae_pkg::t_mem_wr            w_mem_wr;
    logic [3:0]                  w_mem_raddr;
    logic [sae_pkg::ENTRY_W-1:0] w_mem_rdata;
    sae_pkg::t_div_req           w_div_req;
    sae_pkg::t_div_rsp           w_div_rsp;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upf <= 8'd4;
            r_dvr <= 8'd1;
            r_sus <= '0;
            r_fos <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                sae_pkg::REG_UPF: r_upf <= pwdata[7:0];
                sae_pkg::REG_DIV: r_dvr <= pwdata[7:0];
                sae_pkg::REG_SUS: r_sus <= pwdata[23:0];
                sae_pkg::REG_FOS: r_fos <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sae_pkg::REG_UPF: prdata = {24'd0, r_upf};
            sae_pkg::REG_DIV: prdata = {24'd0, r_dvr};
            sae_pkg::REG_SUS: prdata = {8'd0, r_sus};
            sae_pkg::REG_FOS: prdata = {8'd0, r_fos};
            default:          prdata = '0;
        endcase
    end

    sae_script_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_mem_wr),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    sae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    sae_ctrl #(
        .ENV_DEPTH    (ENV_DEPTH),
        .SUSTAIN_HOLD (SUSTAIN_HOLD)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_word      (i_word),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_upf       (r_upf),
        .i_dvr       (r_dvr),
        .i_sus       (r_sus),
        .i_fos       (r_fos),
        .o_mem_wr    (w_mem_wr),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

endmodule
